/* hdl/pidfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pidfd_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned GAIN_W    = 31;
    localparam int unsigned POLE_W    = 16;
    localparam int unsigned DRIVE_W   = 25;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STAGES    = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_DERIV_POLE = 3'd3,
        CFG_OUT_MIN    = 3'd4,
        CFG_OUT_MAX    = 3'd5
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 31'd655360;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 31'd82;
    localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = 31'd1048576;
    localparam logic [POLE_W-1:0]        DERIV_POLE_RST = 16'd39322;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST    = -32'sd21790;
    localparam logic [GAIN_W-1:0]        OUT_MAX_RST    = 31'd21790;

    localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 25'sd16711680;

    localparam logic signed [63:0] RND_HALF = 64'sd32768;
    localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] y;
        if (x > S32_MAX) begin
            y = S32_MAX[DATA_W-1:0];
        end else if (x < S32_MIN) begin
            y = S32_MIN[DATA_W-1:0];
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

    // round to nearest, halves towards plus infinity, then drop 16 fraction bits
    function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + RND_HALF;
        return t[63:16];
    endfunction

endpackage

`default_nettype wire

/* hdl/pidfd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pidfd_in_if;
    import pidfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

`default_nettype wire

/* hdl/pidfd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pidfd_out_if;
    import pidfd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  pid_output;
    logic signed [DRIVE_W-1:0] drive_value;

    modport source (output valid, output pid_output, output drive_value, input ready);
    modport sink   (input valid, input pid_output, input drive_value, output ready);
endinterface

`default_nettype wire

/* hdl/pid_filtered_derivative.sv */
`timescale 1ns / 1ps
`default_nettype none

// PID speed controller on Q16.16 samples: proportional term, trapezoidal integrator clamped
// to the room left between the output limits and the proportional term, derivative on the
// measurement through a first-order low-pass, output saturation and a drive accumulator
// clamped to +/-255.0. A six-stage pipeline takes one sample per clock cycle while the output
// is not stalled; a stalled output only holds the stages that are full. Stages 1, 3 and 5
// close the controller state loops, the longest being the 16x32 pole multiply of the
// derivative filter. Limits and gains are written through the configuration port; the user
// must write them only while no sample is in flight, as the block does not enforce it.
module pid_filtered_derivative (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [pidfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [pidfd_pkg::DATA_W-1:0]     i_cfg_data,
    pidfd_in_if.sink                        i_smp,
    pidfd_out_if.source                     o_res
);
    import pidfd_pkg::*;

    logic [GAIN_W-1:0]        r_cfg_pg;
    logic [GAIN_W-1:0]        r_cfg_ig;
    logic [GAIN_W-1:0]        r_cfg_dg;
    logic [POLE_W-1:0]        r_cfg_pole;
    logic signed [DATA_W-1:0] r_cfg_omin;
    logic [GAIN_W-1:0]        r_cfg_omax;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;
    logic [STAGES-1:0] w_ld;

    logic signed [DATA_W-1:0]  r0_sp, r0_meas;
    logic signed [DATA_W-1:0]  r1_err;
    logic signed [DATA_W:0]    r1_esum, r1_dmeas;
    logic signed [DATA_W-1:0]  r2_prop;
    logic signed [47:0]        r2_iinc, r2_dinc;
    logic signed [DATA_W-1:0]  r3_prop;
    logic signed [DATA_W-1:0]  r4_sum;
    logic signed [DATA_W-1:0]  r5_sum;

    logic signed [DATA_W-1:0]  r_prev_err, r_prev_meas, r_integ, r_filt;
    logic signed [DRIVE_W-1:0] r_drive_acc;

    logic signed [DATA_W-1:0]  w_err;
    logic signed [DATA_W:0]    w_esum, w_dmeas;
    logic signed [63:0]        w_pprod, w_iprod, w_dprod;
    logic signed [33:0]        w_max34, w_min34, w_prop34, w_hi, w_lo;
    logic signed [48:0]        w_itry, w_iclamp, w_fprod;
    logic signed [DATA_W-1:0]  w_integ, w_deriv;
    logic signed [33:0]        w_sum, w_sumc;
    logic signed [32:0]        w_drv, w_drvc;
    logic                      w_in_acc, w_out_acc;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pg   <= PROP_GAIN_RST;
            r_cfg_ig   <= INTEG_GAIN_RST;
            r_cfg_dg   <= DERIV_GAIN_RST;
            r_cfg_pole <= DERIV_POLE_RST;
            r_cfg_omin <= OUT_MIN_RST;
            r_cfg_omax <= OUT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:  r_cfg_pg   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_cfg_ig   <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_cfg_dg   <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_POLE: r_cfg_pole <= i_cfg_data[POLE_W-1:0];
                CFG_OUT_MIN:    r_cfg_omin <= $signed(i_cfg_data);
                CFG_OUT_MAX:    r_cfg_omax <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow: a stage loads when empty or when its content moves on
    always_comb begin
        w_en[5] = !r_v[5] || o_res.ready;
        w_en[4] = !r_v[4] || w_en[5];
        w_en[3] = !r_v[3] || w_en[4];
        w_en[2] = !r_v[2] || w_en[3];
        w_en[1] = !r_v[1] || w_en[2];
        w_en[0] = !r_v[0] || w_en[1];
        w_ld    = w_en & {r_v[STAGES-2:0], i_smp.valid};
    end

    assign i_smp.ready = w_en[0] && i_rst_n;
    assign w_in_acc    = i_smp.valid && i_smp.ready;
    assign w_out_acc   = r_v[5] && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= w_ld | (r_v & ~w_en);
        end
    end

    // error and differences
    always_comb begin
        w_err   = sat32(64'(r0_sp) - 64'(r0_meas));
        w_esum  = 33'(w_err) + 33'(r_prev_err);
        w_dmeas = 33'(r0_meas) - 33'(r_prev_meas);
    end

    // products
    always_comb begin
        w_pprod = 64'($signed({1'b0, r_cfg_pg})) * 64'(r1_err);
        w_iprod = 64'($signed({1'b0, r_cfg_ig})) * 64'(r1_esum);
        w_dprod = 64'($signed({1'b0, r_cfg_dg})) * 64'(r1_dmeas);
    end

    // integrator with anti-windup window, derivative filter
    always_comb begin
        w_max34  = 34'($signed({1'b0, r_cfg_omax}));
        w_min34  = 34'(r_cfg_omin);
        w_prop34 = 34'(r2_prop);
        w_hi     = (w_max34 > w_prop34) ? w_max34 - w_prop34 : '0;
        w_lo     = (w_min34 < w_prop34) ? w_min34 - w_prop34 : '0;
        w_itry   = 49'(r_integ) + 49'(r2_iinc);
        if (w_itry > 49'(w_hi)) begin
            w_iclamp = 49'(w_hi);
        end else if (w_itry < 49'(w_lo)) begin
            w_iclamp = 49'(w_lo);
        end else begin
            w_iclamp = w_itry;
        end
        w_integ = sat32(64'(w_iclamp));
        w_fprod = 49'($signed({1'b0, r_cfg_pole})) * 49'(r_filt);
        w_deriv = sat32(64'(rnd16(64'(w_fprod))) - 64'(r2_dinc));
    end

    // sum and output limits, upper limit tested first
    always_comb begin
        w_sum = 34'(r3_prop) + 34'(r_integ) + 34'(r_filt);
        if (w_sum > w_max34) begin
            w_sumc = w_max34;
        end else if (w_sum < w_min34) begin
            w_sumc = w_min34;
        end else begin
            w_sumc = w_sum;
        end
    end

    // drive accumulator
    always_comb begin
        w_drv = 33'(r_drive_acc) + 33'(r4_sum);
        if (w_drv > 33'(DRIVE_LIMIT)) begin
            w_drvc = 33'(DRIVE_LIMIT);
        end else if (w_drv < -33'(DRIVE_LIMIT)) begin
            w_drvc = -33'(DRIVE_LIMIT);
        end else begin
            w_drvc = w_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r0_sp   <= i_smp.setpoint;
            r0_meas <= i_smp.measurement;
        end
        if (w_ld[1]) begin
            r1_err   <= w_err;
            r1_esum  <= w_esum;
            r1_dmeas <= w_dmeas;
        end
        if (w_ld[2]) begin
            r2_prop <= sat32(64'(rnd16(w_pprod)));
            r2_iinc <= rnd16(w_iprod);
            r2_dinc <= rnd16(w_dprod);
        end
        if (w_ld[3]) begin
            r3_prop <= r2_prop;
        end
        if (w_ld[4]) begin
            r4_sum <= w_sumc[DATA_W-1:0];
        end
        if (w_ld[5]) begin
            r5_sum <= r4_sum;
        end
    end

    // controller state: advance only with the transaction passing each stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_prev_meas <= '0;
            r_integ     <= '0;
            r_filt      <= '0;
            r_drive_acc <= '0;
        end else begin
            if (w_ld[1]) begin
                r_prev_err  <= w_err;
                r_prev_meas <= r0_meas;
            end
            if (w_ld[3]) begin
                r_integ <= w_integ;
                r_filt  <= w_deriv;
            end
            if (w_ld[5]) begin
                r_drive_acc <= w_drvc[DRIVE_W-1:0];
            end
        end
    end

    assign o_res.valid       = r_v[5];
    assign o_res.pid_output  = r5_sum;
    assign o_res.drive_value = r_drive_acc;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive_acc <= DRIVE_LIMIT) && (r_drive_acc >= -DRIVE_LIMIT))
        else $error("drive accumulator out of range");

    a_out_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && (33'(r_cfg_omin) <= 33'($signed({1'b0, r_cfg_omax}))))
        |-> ((33'(r5_sum) <= 33'($signed({1'b0, r_cfg_omax})))
             && (r5_sum >= r_cfg_omin)))
        else $error("output outside limits");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_v) ==
            $past($countones(r_v)) + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("pipeline occupancy mismatch");

    a_filt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_ld[3] && !w_ld[1]) |=> ($stable(r_filt) && $stable(r_integ)
                                    && $stable(r_prev_err)))
        else $error("controller state moved without a transaction");

endmodule

`default_nettype wire
